// ===== src/lrupr_pkg.sv =====
// shared constants and controller/datapath interface types for the lru page replacement block
package lrupr_pkg;

    localparam int NUM_PAGES_DEF = 64;
    localparam int AGE_WIDTH_DEF = 16;

    localparam int PAGE_NUM_W = 6;
    localparam int FRAME_W    = 7;
    localparam int FAULT_W    = 32;

    localparam logic [FRAME_W-1:0] FRAME_COUNT_RST = FRAME_W'(4);
    localparam logic [FRAME_W-1:0] FRAME_MAX       = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX       = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_wr;   // write a zero entry at the sweep counter
        logic load;     // capture an input transaction
        logic scan_rd;  // read the entry at the sweep counter
        logic update;   // decide hit, fill or eviction
        logic finish;   // move the result into the output registers
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic cnt_last;  // sweep counter sits on the last page
        logic page_oor;  // incoming page number is beyond the page table
    } sts_t;

endpackage

// ===== src/lrupr_ctrl.sv =====
// sequencing state machine: clearing pass, age scan, update and result handoff
module lrupr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  lrupr_pkg::sts_t sts,
    output lrupr_pkg::cmd_t cmd
);
    import lrupr_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.page_oor ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last write-back of the scan happens here
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== src/lrupr_dp.sv =====
// datapath: age/resident memory, victim search, frame and fault counters, result registers
module lrupr_dp #(
    parameter int NUM_PAGES = lrupr_pkg::NUM_PAGES_DEF,
    parameter int AGE_WIDTH = lrupr_pkg::AGE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lrupr_pkg::cmd_t                    cmd,
    output lrupr_pkg::sts_t                    sts,
    input  logic                               cfg_wr_en,
    input  logic [lrupr_pkg::FRAME_W-1:0]      cfg_wr_data,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]   s_page_number,
    output logic                               m_hit,
    output logic                               m_evicted,
    output logic [lrupr_pkg::PAGE_NUM_W-1:0]   m_victim_page,
    output logic [lrupr_pkg::FAULT_W-1:0]      m_fault_count
);
    import lrupr_pkg::*;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int ENTRY_W = AGE_WIDTH + 1;
    localparam logic [PAGE_W-1:0]    LAST_IDX = PAGE_W'(NUM_PAGES - 1);
    localparam logic [AGE_WIDTH-1:0] AGE_MAX  = '1;

    // entry layout: {resident, age}
    logic [ENTRY_W-1:0] age_mem [NUM_PAGES];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic                  mem_we;
    logic [PAGE_W-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    logic [FRAME_W-1:0]    frame_count_reg, frame_count_next;
    logic [FRAME_W-1:0]    used_frames_reg, used_frames_next;
    logic [FAULT_W-1:0]    faults_reg, faults_next;
    logic [PAGE_W-1:0]     cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [PAGE_W-1:0]     pipe_addr_reg, pipe_addr_next;
    logic [PAGE_NUM_W-1:0] page_reg, page_next;
    logic [AGE_WIDTH-1:0]  best_age_reg, best_age_next;
    logic [PAGE_W-1:0]     best_idx_reg, best_idx_next;
    logic                  found_reg, found_next;
    logic                  hit_reg, hit_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  res_evict_reg, res_evict_next;
    logic [PAGE_NUM_W-1:0] res_victim_reg, res_victim_next;

    logic [PAGE_W-1:0]     page_idx;
    logic [FRAME_W-1:0]    frames;
    logic                  old_res;
    logic [AGE_WIDTH-1:0]  old_age;
    logic                  is_page;
    logic [AGE_WIDTH-1:0]  new_age;
    logic                  new_res;

    assign page_idx = PAGE_W'(page_reg);
    assign frames   = (frame_count_reg == '0) ? FRAME_W'(1) : frame_count_reg;

    assign old_res = rd_data_reg[AGE_WIDTH];
    assign old_age = rd_data_reg[AGE_WIDTH-1:0];
    assign is_page = (pipe_addr_reg == page_idx);
    assign new_age = is_page ? '0 : ((old_age == AGE_MAX) ? old_age : old_age + 1'b1);
    assign new_res = is_page ? 1'b1 : old_res;

    assign sts.cnt_last = (cnt_reg == LAST_IDX);
    assign sts.page_oor = (32'(s_page_number) >= 32'(NUM_PAGES));

    always_comb begin
        frame_count_next = frame_count_reg;
        used_frames_next = used_frames_reg;
        faults_next      = faults_reg;
        cnt_next         = cnt_reg;
        pend_next        = cmd.scan_rd;
        pipe_addr_next   = pipe_addr_reg;
        page_next        = page_reg;
        best_age_next    = best_age_reg;
        best_idx_next    = best_idx_reg;
        found_next       = found_reg;
        hit_next         = hit_reg;
        res_hit_next     = res_hit_reg;
        res_evict_next   = res_evict_reg;
        res_victim_next  = res_victim_reg;
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg;
        mem_wdata        = '0;

        if (cfg_wr_en) begin
            frame_count_next = cfg_wr_data;
        end

        if (cmd.load) begin
            cnt_next        = '0;
            page_next       = s_page_number;
            best_age_next   = '0;
            best_idx_next   = '0;
            found_next      = 1'b0;
            hit_next        = 1'b0;
            res_hit_next    = 1'b0;
            res_evict_next  = 1'b0;
            res_victim_next = '0;
        end else if (cmd.clr_wr || cmd.scan_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.clr_wr) begin
            mem_we = 1'b1;
        end

        if (cmd.scan_rd) begin
            pipe_addr_next = cnt_reg;
        end

        // write-back of the entry read last cycle, with the running maximum
        if (pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pipe_addr_reg;
            mem_wdata = {new_res, new_age};
            if (is_page) begin
                hit_next = old_res;
            end else if (old_res && (new_age >= best_age_reg)) begin
                best_age_next = new_age;
                best_idx_next = pipe_addr_reg;
                found_next    = 1'b1;
            end
        end

        if (cmd.update) begin
            if (hit_reg) begin
                res_hit_next = 1'b1;
            end else if (used_frames_reg < frames) begin
                used_frames_next = used_frames_reg + 1'b1;
            end else if (found_reg) begin
                mem_we          = 1'b1;
                mem_waddr       = best_idx_reg;
                mem_wdata       = {1'b0, best_age_reg};
                res_evict_next  = 1'b1;
                res_victim_next = PAGE_NUM_W'(best_idx_reg);
                if (faults_reg != FAULT_MAX) begin
                    faults_next = faults_reg + 1'b1;
                end
            end else if (used_frames_reg != FRAME_MAX) begin
                used_frames_next = used_frames_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_data_reg <= age_mem[cnt_reg];
        end
        if (mem_we) begin
            age_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FRAME_COUNT_RST;
            used_frames_reg <= '0;
            faults_reg      <= '0;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
        end else begin
            frame_count_reg <= frame_count_next;
            used_frames_reg <= used_frames_next;
            faults_reg      <= faults_next;
            cnt_reg         <= cnt_next;
            pend_reg        <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_addr_reg  <= pipe_addr_next;
        page_reg       <= page_next;
        best_age_reg   <= best_age_next;
        best_idx_reg   <= best_idx_next;
        found_reg      <= found_next;
        hit_reg        <= hit_next;
        res_hit_reg    <= res_hit_next;
        res_evict_reg  <= res_evict_next;
        res_victim_reg <= res_victim_next;
        if (cmd.finish) begin
            m_hit         <= res_hit_reg;
            m_evicted     <= res_evict_reg;
            m_victim_page <= res_victim_reg;
            m_fault_count <= faults_reg;
        end
    end

endmodule

// ===== src/lru_page_replacement.sv =====
// lru page replacement top level: one access in, one result out per transaction
// flow: a new transaction is accepted only once the previous one has moved its result
//   to the output registers; the age memory scan sets the pace
//   (one entry read and written back per cycle through a separate read port and write port)
// reset: control state clears at once, then a clearing pass over all NUM_PAGES entries zeroes
//   the age memory with s_ready low; configuration writes are taken throughout
module lru_page_replacement #(
    parameter int NUM_PAGES = lrupr_pkg::NUM_PAGES_DEF,
    parameter int AGE_WIDTH = lrupr_pkg::AGE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lrupr_pkg::FRAME_W-1:0]      cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]   s_page_number,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic                               m_evicted,
    output logic [lrupr_pkg::PAGE_NUM_W-1:0]   m_victim_page,
    output logic [lrupr_pkg::FAULT_W-1:0]      m_fault_count
);
    import lrupr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lrupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lrupr_dp #(
        .NUM_PAGES (NUM_PAGES),
        .AGE_WIDTH (AGE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_page_number (s_page_number),
        .m_hit         (m_hit),
        .m_evicted     (m_evicted),
        .m_victim_page (m_victim_page),
        .m_fault_count (m_fault_count)
    );

endmodule

// ===== src/lrupr_checker.sv =====
// port-level checker for the lru page replacement block, bound to the top level
module lrupr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic        m_evicted,
    input logic [5:0]  m_victim_page,
    input logic [31:0] m_fault_count
);

    // one access at a time: no back-to-back input transactions
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous access in flight");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("result shows both hit and eviction");

    // victim page reads zero without an eviction
    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> (m_victim_page == 6'd0))
        else $error("victim page nonzero without eviction");

    // an eviction is a fault, so the count cannot be zero
    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> (m_fault_count != 32'd0))
        else $error("eviction reported with zero fault count");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_fault_count)))
        else $error("stalled result changed");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);
